### rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache.
package lfu_pkg;

  localparam int KeyW   = 32;
  localparam int ValW   = 32;
  localparam int FreqW  = 32;
  localparam int StampW = 48;
  localparam int CapW   = 5;

  localparam logic       OpGet    = 1'b0;
  localparam logic       OpPut    = 1'b1;
  localparam logic [CapW-1:0] CapReset = CapW'(16);
  localparam logic [FreqW-1:0] FreqMax = '1;

  typedef struct packed {
    logic              vld;
    logic              found;
    logic [ValW-1:0]   rvalue;
    logic              have;
    logic [FreqW-1:0]  vfreq;
    logic [StampW-1:0] vstamp;
    logic              hasfree;
  } carry_t;

  typedef struct packed {
    logic              en;
    logic              bump;
    logic              setval;
    logic              insert;
    logic              clr;
    logic [StampW-1:0] stamp;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   val;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_WRITE  = 4'b1000
  } state_t;

endpackage

### rtl/lfu_if.sv
// Request and response channel interfaces of the LFU cache.
interface lfu_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic signed [31:0] key;
  logic signed [31:0] value;
  modport source(output valid, opcode, key, value, input ready);
  modport sink(input valid, opcode, key, value, output ready);
endinterface

interface lfu_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic signed [31:0] read_value;
  modport source(output valid, hit, read_value, input ready);
  modport sink(input valid, hit, read_value, output ready);
endinterface

### rtl/lfu_cell.sv
// One cache entry with its stage of the lookup and victim scan chain.
module lfu_cell #(
  parameter int IW      = 4,
  parameter int UW      = 5,
  parameter int INDEX   = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [lfu_pkg::KeyW-1:0] rkey,
  input  lfu_pkg::carry_t         ci,
  input  logic [IW-1:0]           ci_slot,
  input  logic [IW-1:0]           ci_vidx,
  input  logic [IW-1:0]           ci_free,
  input  logic [UW-1:0]           ci_used,
  output lfu_pkg::carry_t         co,
  output logic [IW-1:0]           co_slot,
  output logic [IW-1:0]           co_vidx,
  output logic [IW-1:0]           co_free,
  output logic [UW-1:0]           co_used,
  input  lfu_pkg::cmd_t           cmd,
  input  logic [IW-1:0]           cmd_idx,
  input  logic [IW-1:0]           clr_idx
);
  import lfu_pkg::*;

  localparam logic [IW-1:0] Me = IW'(INDEX);

  logic              valid;
  logic [KeyW-1:0]   key;
  logic [ValW-1:0]   value;
  logic [FreqW-1:0]  freq;
  logic [StampW-1:0] stamp;
  logic              match;
  logic              better;

  assign match  = valid && (key == rkey);
  assign better = valid && (!ci.have || (freq < ci.vfreq) ||
                  ((freq == ci.vfreq) && (stamp < ci.vstamp)));

  always_ff @(posedge clk) begin
    if (rst) begin
      co.vld <= 1'b0;
    end else begin
      co.vld <= ci.vld;
    end
    if (ci.vld) begin
      co.found   <= ci.found || match;
      co_slot    <= ci.found ? ci_slot : Me;
      co.rvalue  <= ci.found ? ci.rvalue : value;
      co_used    <= ci_used + UW'(valid);
      co.have    <= ci.have || better;
      co_vidx    <= better ? Me : ci_vidx;
      co.vfreq   <= better ? freq : ci.vfreq;
      co.vstamp  <= better ? stamp : ci.vstamp;
      co.hasfree <= ci.hasfree || !valid;
      co_free    <= (ci.hasfree || valid) ? ci_free : Me;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (cmd.en && cmd.insert && (cmd_idx == Me)) begin
        valid <= 1'b1;
      end else if (cmd.en && cmd.clr && (clr_idx == Me)) begin
        valid <= 1'b0;
      end
    end
    if (cmd.en && (cmd_idx == Me)) begin
      if (cmd.insert) begin
        key   <= cmd.key;
        value <= cmd.val;
        freq  <= FreqW'(1);
        stamp <= cmd.stamp;
      end else if (cmd.bump) begin
        if (freq != FreqMax) begin
          freq <= freq + FreqW'(1);
        end
        stamp <= cmd.stamp;
        if (cmd.setval) begin
          value <= cmd.val;
        end
      end
    end
  end

endmodule

### rtl/lfu_cache.sv
// Top level of the LFU cache: request control, cell chain and response register.
// Each request travels down a chain of ENTRIES cells, one cell per cycle,
// gathering the key match, occupancy, first free slot and the least used,
// oldest entry. The launch state starts it and the write-back state loads
// the response; the input is ready again in the cycle the response is
// loaded, so a new request is taken only after the previous one has been
// written back. A waiting response holds the write-back and so the next
// request. A full cache evicts the entry with the lowest count, the oldest
// touch breaking ties. Capacity may be written only while idle; zero
// disables inserts.
module lfu_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    capacity_we,
  input  logic [lfu_pkg::CapW-1:0] capacity_wdata,
  lfu_req_if.sink                 req,
  lfu_rsp_if.source               rsp
);
  import lfu_pkg::*;

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW0 = $clog2(ENTRIES + 1);
  localparam int UW  = (CW0 > CapW) ? CW0 : CapW;

  state_t            state;
  logic [CapW-1:0]   capacity;
  logic              rop;
  logic [KeyW-1:0]   rkey;
  logic [ValW-1:0]   rval;
  logic [StampW-1:0] counter;

  carry_t            cc   [0:ENTRIES];
  logic [IW-1:0]     cslot[0:ENTRIES];
  logic [IW-1:0]     cvidx[0:ENTRIES];
  logic [IW-1:0]     cfree[0:ENTRIES];
  logic [UW-1:0]     cused[0:ENTRIES];

  cmd_t              cmd;
  logic [IW-1:0]     cmd_idx;
  logic [IW-1:0]     clr_idx;
  carry_t            last;
  logic [UW-1:0]     cap_eff;
  logic              evict;
  logic              write_go;

  assign req.ready = (state == ST_IDLE);
  assign last      = cc[ENTRIES];
  assign cap_eff   = (UW'(capacity) > UW'(ENTRIES)) ? UW'(ENTRIES) : UW'(capacity);
  assign write_go  = (state == ST_WRITE) && (!rsp.valid || rsp.ready);

  always_comb begin
    cc[0]         = '0;
    cc[0].vld     = (state == ST_LAUNCH);
    cslot[0]      = '0;
    cvidx[0]      = '0;
    cfree[0]      = '0;
    cused[0]      = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell #(.IW(IW), .UW(UW), .INDEX(i)) u_cell (
      .clk(clk), .rst(rst), .rkey(rkey),
      .ci(cc[i]), .ci_slot(cslot[i]), .ci_vidx(cvidx[i]),
      .ci_free(cfree[i]), .ci_used(cused[i]),
      .co(cc[i+1]), .co_slot(cslot[i+1]), .co_vidx(cvidx[i+1]),
      .co_free(cfree[i+1]), .co_used(cused[i+1]),
      .cmd(cmd), .cmd_idx(cmd_idx), .clr_idx(clr_idx)
    );
  end

  always_comb begin
    evict      = last.have && (cused[ENTRIES] >= cap_eff);
    cmd        = '0;
    cmd.stamp  = counter + StampW'(1);
    cmd.key    = rkey;
    cmd.val    = rval;
    cmd_idx    = cslot[ENTRIES];
    clr_idx    = cvidx[ENTRIES];
    if (write_go) begin
      if (last.found) begin
        if (rop == OpGet || cap_eff != '0) begin
          cmd.en     = 1'b1;
          cmd.bump   = 1'b1;
          cmd.setval = (rop == OpPut);
        end
      end else if (rop == OpPut && cap_eff != '0) begin
        cmd.en     = 1'b1;
        cmd.insert = 1'b1;
        if (evict && (!last.hasfree || cvidx[ENTRIES] < cfree[ENTRIES])) begin
          cmd_idx = cvidx[ENTRIES];
        end else begin
          cmd_idx = cfree[ENTRIES];
          cmd.clr = evict;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= CapReset;
      counter   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (capacity_we) begin
        capacity <= capacity_wdata;
      end
      if (cmd.en) begin
        counter <= cmd.stamp;
      end
      if (rsp.valid && rsp.ready && !write_go) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:   if (req.valid) state <= ST_LAUNCH;
        ST_LAUNCH: state <= ST_SCAN;
        ST_SCAN:   if (last.vld) state <= ST_WRITE;
        ST_WRITE:  if (write_go) begin
          state     <= ST_IDLE;
          rsp.valid <= 1'b1;
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      rop  <= req.opcode;
      rkey <= req.key;
      rval <= req.value;
    end
    if (write_go) begin
      rsp.hit        <= last.found;
      rsp.read_value <= (rop == OpGet && last.found) ? last.rvalue : '0;
    end
  end

  a_rsp_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_WRITE))
    else $error("response loaded outside write-back");

  a_chain_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    last.vld |-> (state == ST_SCAN))
    else $error("scan result arrived outside scan");

  a_cmd_then_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.en |=> rsp.valid && (state == ST_IDLE))
    else $error("write-back without response");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the LFU cache: directed and random get/put traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_pkg::*;

  class lfu_scoreboard;
    logic [CapW-1:0]   cap;
    logic              slot_valid[16];
    logic [KeyW-1:0]   slot_key[16];
    logic [ValW-1:0]   slot_value[16];
    logic [FreqW-1:0]  slot_freq[16];
    logic [StampW-1:0] slot_stamp[16];
    logic [StampW-1:0] touch_count;
    logic              hit_q[$];
    logic [ValW-1:0]   value_q[$];
    int                errors;

    function new();
      cap = CapReset;
      touch_count = '0;
      errors = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function void set_capacity(logic [CapW-1:0] c);
      cap = c;
    endfunction

    function int pending();
      return hit_q.size();
    endfunction

    function void touch(int s, logic bump);
      if (bump && slot_freq[s] != FreqMax) slot_freq[s] = slot_freq[s] + FreqW'(1);
      touch_count = touch_count + StampW'(1);
      slot_stamp[s] = touch_count;
    endfunction

    function void note_request(logic op, logic [KeyW-1:0] k, logic [ValW-1:0] v);
      int limit;
      int used;
      int s;
      int victim;
      logic found;
      limit = (cap > 16) ? 16 : int'(cap);
      used = 0;
      s = 0;
      found = 1'b0;
      for (int i = 0; i < 16; i++) begin
        if (slot_valid[i]) begin
          used++;
          if (!found && slot_key[i] == k) begin
            found = 1'b1;
            s = i;
          end
        end
      end
      hit_q = {hit_q, found};
      if (op == OpGet) begin
        value_q = {value_q, (found ? slot_value[s] : ValW'(0))};
        if (found) touch(s, 1'b1);
        return;
      end
      value_q = {value_q, ValW'(0)};
      if (limit == 0) return;
      if (found) begin
        touch(s, 1'b1);
        slot_value[s] = v;
        return;
      end
      if (used >= limit) begin
        victim = -1;
        for (int i = 0; i < 16; i++) begin
          if (!slot_valid[i]) continue;
          if (victim < 0 || slot_freq[i] < slot_freq[victim] ||
              (slot_freq[i] == slot_freq[victim] && slot_stamp[i] < slot_stamp[victim]))
            victim = i;
        end
        if (victim >= 0) slot_valid[victim] = 1'b0;
      end
      for (int i = 0; i < 16; i++) begin
        if (!slot_valid[i]) begin
          slot_valid[i] = 1'b1;
          slot_key[i] = k;
          slot_value[i] = v;
          slot_freq[i] = FreqW'(1);
          touch(i, 1'b0);
          break;
        end
      end
    endfunction

    function void check_response(logic h, logic [ValW-1:0] rv);
      logic eh;
      logic [ValW-1:0] ev;
      if (hit_q.size() == 0) begin
        $error("response with no request outstanding: hit %0d read_value %0h", h, rv);
        errors++;
        return;
      end
      eh = hit_q[0];
      hit_q.delete(0);
      ev = value_q[0];
      value_q.delete(0);
      if (h !== eh) begin
        $error("hit: expected %0d actual %0d", eh, h);
        errors++;
      end
      if (rv !== ev) begin
        $error("read_value: expected %0h actual %0h", ev, rv);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic capacity_we = 1'b0;
  logic [CapW-1:0] capacity_wdata = '0;
  int rsp_stall_pct = 0;
  int rsp_hold = 0;
  lfu_scoreboard sb = new();

  lfu_req_if req_if();
  lfu_rsp_if rsp_if();

  lfu_cache DUT (
    .clk(clk), .rst(rst), .capacity_we(capacity_we), .capacity_wdata(capacity_wdata),
    .req(req_if.sink), .rsp(rsp_if.source)
  );

  always #5 clk = ~clk;

  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = OpGet;
    req_if.key = '0;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (rsp_hold > 0) begin
      rsp_if.ready = 1'b0;
      rsp_hold--;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.opcode, req_if.key, req_if.value);
      if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.hit, rsp_if.read_value);
    end
  end

  task automatic send_item(logic op, logic [31:0] k, logic [31:0] v, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.opcode = op;
    req_if.key = k;
    req_if.value = v;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CapW-1:0] c);
    capacity_we = 1'b1;
    capacity_wdata = c;
    @(negedge clk);
    capacity_we = 1'b0;
    sb.set_capacity(c);
  endtask

  task automatic random_items(int n, int idle_pct);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) < 8) ? 32'($urandom_range(23)) - 32'd12 : $urandom();
      send_item(logic'($urandom_range(1)), k, $urandom(), idle_pct);
    end
  endtask

  initial begin
    logic [CapW-1:0] caps[7] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd3, 5'd16, 5'd8};
    int send_idle[4] = '{0, 49, 0, 29};
    int recv_stall[4] = '{0, 0, 49, 29};
    repeat (9) @(negedge clk);
    rst = 1'b0;
    send_item(OpPut, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_item(OpPut, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_item(OpPut, 32'h0, 32'hFFFF_FFFF, 0);
    send_item(OpPut, 32'hFFFF_FFFF, 32'h0, 0);
    send_item(OpGet, 32'h8000_0000, 32'h1234_5678, 0);
    send_item(OpGet, 32'h7FFF_FFFF, 32'h0, 0);
    send_item(OpGet, 32'h0, 32'h0, 0);
    send_item(OpGet, 32'hFFFF_FFFF, 32'h0, 0);
    send_item(OpGet, 32'h5555_AAAA, 32'h0, 0);
    send_item(OpPut, 32'h0, 32'hAAAA_5555, 0);
    send_item(OpGet, 32'h0, 32'h0, 0);
    for (int i = 1; i <= 14; i++) send_item(OpPut, 32'(i * 100), 32'(i), 0);
    drain();
    write_capacity(5'd2);
    send_item(OpPut, 32'd7, 32'd70, 0);
    send_item(OpGet, 32'd7, 32'd0, 0);
    drain();
    write_capacity(5'd0);
    send_item(OpPut, 32'd9, 32'd90, 0);
    send_item(OpGet, 32'd9, 32'd0, 0);
    send_item(OpPut, 32'd7, 32'd71, 0);
    send_item(OpGet, 32'd7, 32'd0, 0);
    drain();
    for (int p = 0; p < 7; p++) begin
      write_capacity(caps[p]);
      rsp_stall_pct = recv_stall[p % 4];
      if (p == 4) rsp_hold = 300;
      random_items(125, send_idle[p % 4]);
      drain();
    end
    rsp_stall_pct = 0;
    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending() != 0) $error("%0d responses never arrived", sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

### lfu_cache.f
rtl/lfu_pkg.sv
rtl/lfu_if.sv
rtl/lfu_cell.sv
rtl/lfu_cache.sv
tb/tb_top.sv
